@@ rtl/grp_pkg.sv @@
// Package for the grid rectangle placer: operation and status codes, entry type.
// No dependencies.
package grp_pkg;

    // Positions are four bits wide, so the grid is fixed at 16 by 16 cells.
    localparam int GRID_W = 16;
    localparam int GRID_H = 16;

    typedef enum logic [2:0] {
        OP_PLACE_AT = 3'd0,
        OP_PLACE_FF = 3'd1,
        OP_MOVE     = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_TAKE     = 3'd4
    } t_op;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [15:0] tag;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [4:0]  w;
        logic [4:0]  h;
    } t_entry;

endpackage

@@ rtl/grp_entry_ram.sv @@
// Entry table memory of the grid rectangle placer: one write port, one read
// port, registered read data. Depends on grp_pkg.
module grp_entry_ram
    import grp_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic   i_clk,
    input  logic   i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry o_rdata
);

    t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ rtl/grid_rectangle_placer.sv @@
// Top level of the grid rectangle placer: command decode, scan sequencer and
// entry table. Depends on grp_pkg and grp_entry_ram.
//
// Usage. A command is transferred at a rising edge where i_start is high and
// o_busy is low; the opcode and operands are sampled then. While the command
// runs, o_busy stays high. Exactly one result is transferred per command: it
// appears on o_status, o_placed_x, o_placed_y and o_entry_count for one cycle
// with o_done high, and the receiver cannot hold it off. o_busy falls in the
// same cycle, so the next command may start right after.
//
// Timing. Every command walks the table through the single read port of the
// entry memory, one entry per cycle. A lookup walks the held entries until
// one matches, a removal then walks the entries after the match to close the
// gap, and a fit test over one candidate origin walks the held entries until
// one overlaps. First fit tries origins row by row, up to one fit test per
// origin of the grid; this search loop over the memory port sets the worst
// case. Place-at and move use one fit test. Reset empties the table at once
// (the held count is cleared); the entries themselves are never cleared,
// since only entries below the count are read.
module grid_rectangle_placer
    import grp_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_item_tag,
    input  logic [4:0]  i_item_width,
    input  logic [4:0]  i_item_height,
    input  logic [3:0]  i_pos_x,
    input  logic [3:0]  i_pos_y,
    input  logic [3:0]  i_dest_x,
    input  logic [3:0]  i_dest_y,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_placed_x,
    output logic [3:0]  o_placed_y,
    output logic [5:0]  o_entry_count
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_FIT, S_SHIFT, S_RESULT
    } t_state;

    t_state r_state;
    logic [2:0]   r_op;
    logic [15:0]  r_tag;
    logic [4:0]   r_w, r_h;
    logic [3:0]   r_px, r_py, r_dx, r_dy;
    logic [CW-1:0] r_count;
    // Read pointer issues addresses; r_rv marks that o_rdata holds entry r_ridx.
    logic [CW-1:0] r_rptr;
    logic          r_rv;
    logic [CW-1:0] r_ridx;
    logic [CW-1:0] r_k;       // matched entry
    logic          r_conflict;
    logic [6:0]    r_cx, r_cy; // candidate origin for the fit
    logic          r_ff;      // first-fit search in progress
    logic [1:0]    r_status;
    logic [3:0]    r_ox, r_oy;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    logic          fit_we;
    logic [AW-1:0] fit_waddr;
    t_entry        fit_wdata;
    logic [15:0]   r_keep_tag;
    t_entry        mem2_wdata;

    logic          we_all;
    logic [AW-1:0] waddr_all;
    t_entry        wdata_all;

    grp_entry_ram #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we_all),
        .i_waddr (waddr_all),
        .i_wdata (wdata_all),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Read address and overlap/cover tests on the entry just read.
    logic          rd_go;
    logic          covers, tag_hit, overlaps, cand_ok;
    logic [6:0]    ex_end, ey_end, cx_end, cy_end;

    always_comb begin
        raddr  = r_rptr[AW-1:0];
        ex_end = 7'(rdata.x) + 7'(rdata.w);
        ey_end = 7'(rdata.y) + 7'(rdata.h);
        cx_end = r_cx + 7'(r_w);
        cy_end = r_cy + 7'(r_h);
        covers = (rdata.x <= r_px) && (7'(r_px) < ex_end)
              && (rdata.y <= r_py) && (7'(r_py) < ey_end);
        tag_hit = (rdata.tag == r_tag);
        overlaps = (7'(rdata.x) < cx_end) && (r_cx < ex_end)
                && (7'(rdata.y) < cy_end) && (r_cy < ey_end)
                && (rdata.w != 5'd0) && (rdata.h != 5'd0);
        cand_ok = (r_w != 5'd0) && (r_h != 5'd0)
               && (cx_end <= 7'(GRID_W)) && (cy_end <= 7'(GRID_H));
        rd_go = (r_rptr < r_count);
    end

    // Entry memory write for the gap shift; new entries and move updates use the fit path.
    always_comb begin
        we    = 1'b0;
        waddr = r_ridx[AW-1:0];
        wdata = rdata;
        if (r_state == S_SHIFT && r_rv) begin
            we    = 1'b1;
            waddr = AW'(r_ridx - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            o_done  <= 1'b0;
            fit_we  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            fit_we <= 1'b0;
            r_rv   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op <= i_opcode;  r_tag <= i_item_tag;
                        r_w  <= i_item_width; r_h <= i_item_height;
                        r_px <= i_pos_x; r_py <= i_pos_y;
                        r_dx <= i_dest_x; r_dy <= i_dest_y;
                        r_ox <= 4'd0; r_oy <= 4'd0;
                        r_rptr <= '0;
                        r_conflict <= 1'b0;
                        r_k <= CW'(MAX_ENTRIES);
                        r_ff <= (i_opcode == OP_PLACE_FF);
                        r_cx <= (i_opcode == OP_PLACE_AT) ? 7'(i_pos_x) : 7'd0;
                        r_cy <= (i_opcode == OP_PLACE_AT) ? 7'(i_pos_y) : 7'd0;
                        unique case (i_opcode)
                            OP_PLACE_AT, OP_PLACE_FF: begin
                                if (32'(r_count) >= MAX_ENTRIES) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_state <= S_FIT;
                                end
                            end
                            OP_MOVE, OP_REMOVE, OP_TAKE: r_state <= S_FIND;
                            default: begin
                                r_status <= ST_NO_MATCH;
                                r_state  <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    if (rd_go) begin
                        r_rptr <= r_rptr + CW'(1);
                        r_rv   <= 1'b1;
                        r_ridx <= r_rptr;
                    end
                    if (r_rv && ((r_op == OP_TAKE) ? tag_hit : covers)) begin
                        r_k <= r_ridx;
                        r_rv <= 1'b0;
                        if (r_op == OP_MOVE) begin
                            r_w <= rdata.w; r_h <= rdata.h;
                            r_cx <= 7'(r_dx); r_cy <= 7'(r_dy);
                            r_rptr <= '0;
                            r_state <= S_FIT;
                        end else begin
                            if (r_op == OP_TAKE) begin
                                r_ox <= rdata.x; r_oy <= rdata.y;
                            end
                            r_rptr <= r_ridx + CW'(1);
                            r_state <= S_SHIFT;
                        end
                    end else if (!rd_go && !r_rv) begin
                        r_status <= ST_NO_MATCH;
                        r_state  <= S_RESULT;
                    end
                end
                S_SHIFT: begin
                    if (rd_go) begin
                        r_rptr <= r_rptr + CW'(1);
                        r_rv   <= 1'b1;
                        r_ridx <= r_rptr;
                    end else if (!r_rv) begin
                        r_count  <= r_count - CW'(1);
                        r_status <= ST_DONE;
                        r_state  <= S_RESULT;
                    end
                end
                S_FIT: begin
                    if (!cand_ok) begin
                        if (r_ff && r_cy < 7'(GRID_H - 1)) begin
                            r_cx <= 7'd0; r_cy <= r_cy + 7'd1;
                        end else begin
                            r_status <= ST_NO_FREE;
                            r_state  <= S_RESULT;
                        end
                    end else begin
                        if (rd_go && !r_conflict) begin
                            r_rptr <= r_rptr + CW'(1);
                            r_rv   <= 1'b1;
                            r_ridx <= r_rptr;
                        end
                        if (r_rv && r_ridx != r_k && overlaps) begin
                            r_conflict <= 1'b1;
                        end
                        if (!r_rv && (!rd_go || r_conflict)) begin
                            r_rptr     <= '0;
                            r_conflict <= 1'b0;
                            if (!r_conflict) begin
                                r_status <= ST_DONE;
                                r_ox <= r_cx[3:0]; r_oy <= r_cy[3:0];
                                fit_we <= 1'b1;
                                if (r_op == OP_MOVE) begin
                                    fit_waddr <= r_k[AW-1:0];
                                end else begin
                                    fit_waddr <= r_count[AW-1:0];
                                    r_count <= r_count + CW'(1);
                                end
                                fit_wdata <= '{tag: r_tag, x: r_cx[3:0], y: r_cy[3:0],
                                               w: r_w, h: r_h};
                                r_state <= S_RESULT;
                            end else if (r_ff) begin
                                r_cx <= r_cx + 7'd1;
                            end else begin
                                r_status <= ST_NO_FREE;
                                r_state  <= S_RESULT;
                            end
                        end
                    end
                end
                S_RESULT: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Move keeps the stored tag: write it back from the value read first.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIND && r_rv && covers && r_op == OP_MOVE) begin
            r_keep_tag <= rdata.tag;
        end
    end

    always_comb begin
        mem2_wdata = fit_wdata;
        if (r_op == OP_MOVE) begin
            mem2_wdata.tag = r_keep_tag;
        end
    end

    // Second write path: committed fit, in S_RESULT (no shift then).
    assign we_all    = we | fit_we;
    assign waddr_all = fit_we ? fit_waddr : waddr;
    assign wdata_all = fit_we ? mem2_wdata : wdata;

    assign o_busy        = (r_state != S_IDLE);
    assign o_status      = r_status;
    assign o_placed_x    = r_ox;
    assign o_placed_y    = r_oy;
    assign o_entry_count = 6'(r_count);

endmodule

@@ rtl/grp_checker.sv @@
// Port-level checker for the grid rectangle placer, bound to the top level.
// Depends on grp_pkg.
module grp_checker
    import grp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [3:0] o_placed_x,
    input logic [3:0] o_placed_y,
    input logic [5:0] o_entry_count
);

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("command not taken");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_placed_x == 4'd0 && o_placed_y == 4'd0))
        else $error("failed command reports a position");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_entry_count == $past(o_entry_count)
                 || o_entry_count == $past(o_entry_count) + 6'd1
                 || o_entry_count == $past(o_entry_count) - 6'd1))
        else $error("count jumped");

endmodule

bind grid_rectangle_placer grp_checker u_grp_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_status,
    .o_placed_x, .o_placed_y, .o_entry_count
);
